// ----- src/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg
// shared constants and types for the sorted insert stack
// ----------------------------------------------------------------------------
package sis_pkg;

   localparam int CAPACITY      = 16;
   localparam int ADDR_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int VALUE_W       = 8;
   localparam int ENTRY_COUNT_W = 5;

   typedef logic [1:0]         op_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   localparam op_type OP_NOP    = 2'd0;
   localparam op_type OP_PUSH   = 2'd1;
   localparam op_type OP_POP    = 2'd2;
   localparam op_type OP_INSERT = 2'd3;

endpackage

// ----- src/sorted_insert_stack.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_stack
// bounded byte stack with push, pop and sorted insert, entries held in a
// synchronous single-read, single-write memory
// ----------------------------------------------------------------------------
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   operation, value
//   rsp_      out         rsp_valid / rsp_stall   top_value, top_valid,
//                                                 entry_count, is_full, accepted
//
// no-op, push, refused word: finish on acceptance; pop: reads new top from
//   memory via ST_POP_WAIT, finishes on acceptance when it empties the stack
// sorted insert: finishes on acceptance when empty or value >= top, else moves
//   entries up through ST_INS_CHECK, paced by the registered read of the entry memory
// one word in flight; result register holds until taken, next word accepted
//   in the cycle the result leaves
// reset clears count and control state; memory contents need no clearing
// ----------------------------------------------------------------------------
module sorted_insert_stack (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sis_pkg::op_type      req_operation,
   input  sis_pkg::value_type   req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sis_pkg::value_type   rsp_top_value,
   output logic                 rsp_top_valid,
   output logic [4:0]           rsp_entry_count,
   output logic                 rsp_is_full,
   output logic                 rsp_accepted
);
   import sis_pkg::*;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_POP_WAIT  = 2'd1;
   localparam logic [1:0] ST_INS_CHECK = 2'd2;
   localparam logic [1:0] ST_INS_PLACE = 2'd3;

   value_type   mem [CAPACITY];

   logic [1:0]  state_ff, state_in;
   count_type   count_ff, count_in;
   value_type   top_ff, top_in;
   addr_type    pos_ff, pos_in;
   value_type   value_ff, value_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        accepted_ff, accepted_in;
   value_type   rdata_ff;

   logic        req_acc;
   logic        slot_free;
   logic        full;
   logic        finish;
   logic        we;
   addr_type    waddr;
   value_type   wdata;
   logic        re;
   addr_type    raddr;
   count_type   count_m1;
   count_type   count_m2;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign req_acc   = req_valid && !req_stall;
   assign count_m1  = count_ff - CNT_W'(1);
   assign count_m2  = count_ff - CNT_W'(2);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      accepted_in = accepted_ff;
      finish      = 1'b0;
      we          = 1'b0;
      waddr       = count_ff[ADDR_W-1:0];
      wdata       = req_value;
      re          = 1'b0;
      raddr       = count_m2[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               value_in    = req_value;
               accepted_in = 1'b1;
               case (req_operation)
                  OP_PUSH: begin
                     finish = 1'b1;
                     if (full) begin
                        accepted_in = 1'b0;
                     end else begin
                        we       = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        top_in   = req_value;
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        accepted_in = 1'b0;
                        finish      = 1'b1;
                     end else begin
                        count_in = count_m1;
                        if (count_ff == CNT_W'(1)) begin
                           finish = 1'b1;
                        end else begin
                           re       = 1'b1;
                           state_in = ST_POP_WAIT;
                        end
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        accepted_in = 1'b0;
                        finish      = 1'b1;
                     end else if (count_ff == '0 || req_value >= top_ff) begin
                        we       = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        top_in   = req_value;
                        finish   = 1'b1;
                     end else begin
                        // old top moves up one place and stays the top
                        we     = 1'b1;
                        wdata  = top_ff;
                        pos_in = count_m1[ADDR_W-1:0];
                        if (count_ff == CNT_W'(1)) begin
                           state_in = ST_INS_PLACE;
                        end else begin
                           re       = 1'b1;
                           state_in = ST_INS_CHECK;
                        end
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_POP_WAIT: begin
            top_in   = rdata_ff;
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_INS_CHECK: begin
            we    = 1'b1;
            waddr = pos_ff;
            if (rdata_ff > value_ff) begin
               wdata = rdata_ff;
               if (pos_ff == ADDR_W'(1)) begin
                  pos_in   = '0;
                  state_in = ST_INS_PLACE;
               end else begin
                  re     = 1'b1;
                  raddr  = pos_ff - ADDR_W'(1) - ADDR_W'(1);
                  pos_in = pos_ff - ADDR_W'(1);
               end
            end else begin
               wdata    = value_ff;
               count_in = count_ff + CNT_W'(1);
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_INS_PLACE: begin
            we       = 1'b1;
            waddr    = pos_ff;
            wdata    = value_ff;
            count_in = count_ff + CNT_W'(1);
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      accepted_ff <= accepted_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_valid   = (count_ff != '0);
   assign rsp_top_value   = rsp_top_valid ? top_ff : '0;
   assign rsp_entry_count = ENTRY_COUNT_W'(count_ff);
   assign rsp_is_full     = full;
   assign rsp_accepted    = accepted_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result shown while word still in work");

   a_full_refuse: assert property (@(posedge clock) disable iff (reset)
      (req_acc && full && (req_operation == OP_PUSH || req_operation == OP_INSERT))
      |=> rsp_valid_ff && !accepted_ff && full)
      else $error("push or insert on full stack not refused");

   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_CHECK) |-> (pos_ff != '0) && (CNT_W'(pos_ff) < count_ff))
      else $error("insert shift position out of range");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_acc) |-> !we)
      else $error("memory written with no word in work");

endmodule

// ----- bench/sorted_insert_stack_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_stack_test
// self-checking bench for the sorted insert stack: a directed opening walks
// empty and full edges, equal keys and every operation, then about two
// thousand random words follow in phases that fill, drain or mix; a shadow
// stack predicts every result word, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module sorted_insert_stack_test;
   import sis_pkg::*;

   typedef struct packed {
      op_type    op;
      value_type val;
   } stack_word_type;

   typedef struct packed {
      value_type                top_value;
      logic                     top_valid;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     is_full;
      logic                     accepted;
   } stack_result_type;

   localparam int RANDOM_WORDS = 1950;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   op_type     req_operation = OP_NOP;
   value_type  req_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   value_type  rsp_top_value;
   logic       rsp_top_valid;
   logic [4:0] rsp_entry_count;
   logic       rsp_is_full;
   logic       rsp_accepted;

   stack_word_type   pending_ops[$];
   stack_result_type expected_tops[$];
   value_type        stack_image[CAPACITY];
   int               stack_depth = 0;

   logic             req_taken = 1'b0;
   int               words_sent = 0;
   int               results_seen = 0;
   int               send_gap = 0;
   int               stall_left = 0;
   bit               long_hold_done = 1'b0;
   int               stall_roll;
   int               errors = 0;
   int               refused_count = 0;
   int               full_count = 0;
   stack_result_type oldest;
   stack_word_type   next_word;

   sorted_insert_stack dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_value   (rsp_top_value),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_full     (rsp_is_full),
      .rsp_accepted    (rsp_accepted)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // shadow stack: applies one word and returns the result it should give
   function automatic stack_result_type apply_stack_op(op_type op, value_type val);
      stack_result_type r;
      int               pos;
      r.accepted = 1'b1;
      case (op)
         OP_PUSH: begin
            if (stack_depth >= CAPACITY) begin
               r.accepted = 1'b0;
            end else begin
               stack_image[stack_depth] = val;
               stack_depth++;
            end
         end
         OP_POP: begin
            if (stack_depth == 0) begin
               r.accepted = 1'b0;
            end else begin
               stack_depth--;
            end
         end
         OP_INSERT: begin
            if (stack_depth >= CAPACITY) begin
               r.accepted = 1'b0;
            end else begin
               pos = stack_depth;
               while (pos > 0 && stack_image[pos-1] > val) begin
                  stack_image[pos] = stack_image[pos-1];
                  pos--;
               end
               stack_image[pos] = val;
               stack_depth++;
            end
         end
         default: ;
      endcase
      if (stack_depth > 0) begin
         r.top_value = stack_image[stack_depth-1];
         r.top_valid = 1'b1;
      end else begin
         r.top_value = '0;
         r.top_valid = 1'b0;
      end
      r.entry_count = ENTRY_COUNT_W'(stack_depth);
      r.is_full     = (stack_depth == CAPACITY);
      if (!r.accepted) refused_count++;
      if (r.is_full) full_count++;
      return r;
   endfunction

   function automatic value_type pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      if (roll < 40) return value_type'($urandom_range(100, 107));
      return value_type'($urandom_range(0, 255));
   endfunction

   // bias 0 fills the stack, 1 drains it, 2 mixes all operations with a mild lean to filling
   function automatic op_type pick_op(int bias);
      int roll;
      roll = $urandom_range(0, 99);
      case (bias)
         0: begin
            if (roll < 5) return OP_NOP;
            if (roll < 30) return OP_PUSH;
            if (roll < 50) return OP_POP;
            return OP_INSERT;
         end
         1: begin
            if (roll < 5) return OP_NOP;
            if (roll < 15) return OP_PUSH;
            if (roll < 75) return OP_POP;
            return OP_INSERT;
         end
         default: begin
            if (roll < 10) return OP_NOP;
            if (roll < 35) return OP_PUSH;
            if (roll < 70) return OP_POP;
            return OP_INSERT;
         end
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic add_word(op_type op, value_type val);
      stack_word_type w;
      w.op  = op;
      w.val = val;
      pending_ops.push_back(w);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_ops.size() > 0) begin
            next_word = pending_ops.pop_front();
            req_valid     <= 1'b1;
            req_operation <= next_word.op;
            req_value     <= next_word.val;
            send_gap      <= ((words_sent / 150) % 4 == 1) ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver pacing, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!long_hold_done && results_seen >= 600) begin
         rsp_stall      <= 1'b1;
         stall_left     <= 400;
         long_hold_done <= 1'b1;
      end else if ((results_seen / 170) % 4 == 2) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 55) begin
            rsp_stall <= 1'b0;
         end else if (stall_roll < 90) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(8, 30);
         end
      end
   end

   // monitor: checks leaving words, then predicts the accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            results_seen <= results_seen + 1;
            if (expected_tops.size() == 0) begin
               errors++;
               $error("result word with nothing expected");
            end else begin
               oldest = expected_tops.pop_front();
               check_field("top_value", oldest.top_value, rsp_top_value);
               check_field("top_valid", oldest.top_valid, rsp_top_valid);
               check_field("entry_count", oldest.entry_count, rsp_entry_count);
               check_field("is_full", oldest.is_full, rsp_is_full);
               check_field("accepted", oldest.accepted, rsp_accepted);
            end
         end
         if (req_valid && !req_stall) begin
            words_sent <= words_sent + 1;
            expected_tops.push_back(apply_stack_op(req_operation, req_value));
         end
      end
   end

   initial begin
      int bias;
      // empty edge, equal keys, order break, fill to full, full edge
      add_word(OP_POP, 8'h00);
      add_word(OP_NOP, 8'h5a);
      add_word(OP_INSERT, 8'h80);
      add_word(OP_INSERT, 8'h00);
      add_word(OP_INSERT, 8'hff);
      add_word(OP_INSERT, 8'h80);
      add_word(OP_PUSH, 8'h07);
      add_word(OP_POP, 8'hff);
      repeat (12) add_word(OP_INSERT, pick_value());
      add_word(OP_PUSH, 8'hff);
      add_word(OP_INSERT, 8'h01);
      add_word(OP_NOP, 8'h00);
      add_word(OP_POP, 8'h00);
      bias = 2;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 60 == 0) bias = $urandom_range(0, 2);
         add_word(pick_op(bias), pick_value());
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_valid || expected_tops.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d words sent, %0d results checked", words_sent, results_seen);
      $display("%0d refused words, %0d results with the stack full",
               refused_count, full_count);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/sis_pkg.sv
src/sorted_insert_stack.sv
bench/sorted_insert_stack_test.sv
